/* sv/sha256_message_hasher_defines.svh */
// assertion macros shared by the sha256 message hasher rtl
// expects aclk and aresetn in the scope where a macro is used
`ifndef SHA256_MESSAGE_HASHER_DEFINES_SVH
`define SHA256_MESSAGE_HASHER_DEFINES_SVH

// condition that must hold on every clock out of reset
`define SMH_CHECK(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// same-cycle implication
`define SMH_CHECK_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

/* sv/smh_pkg.sv */
// types, constants and helper functions for the sha256 message hasher
// no dependencies
`timescale 1ns / 1ps

package smh_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COMP,
        ST_FOLD,
        ST_PAD,
        ST_LEN,
        ST_OUT
    } smh_state_t;

    // controls from the sequencer to the round unit
    typedef struct packed {
        logic        shift_in;
        logic [31:0] word;
        logic        init;
        logic        round;
        logic [31:0] k;
        logic        fold;
        logic        chain_init;
    } smh_ctl_t;

    localparam logic [5:0] PAD_LAST_POS   = 6'd55;
    localparam logic [5:0] BLOCK_LAST_POS = 6'd63;
    localparam logic [5:0] LAST_ROUND     = 6'd63;
    localparam logic [7:0] PAD_MARK       = 8'h80;

    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

/* sv/smh_round.sv */
// shared compression round unit: message schedule window, working
// variables and chain value; depends on smh_pkg
`timescale 1ns / 1ps

module smh_round
    import smh_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  smh_ctl_t        ctl,
    output logic [7:0][31:0] chain_out
);

    logic [31:0] win_reg   [16];
    logic [31:0] win_next  [16];
    logic [31:0] var_reg   [8];
    logic [31:0] var_next  [8];
    logic [31:0] chain_reg [8];
    logic [31:0] chain_next[8];
    logic [31:0] sched;
    logic [31:0] t1;
    logic [31:0] t2;

    always_comb begin
        win_next   = win_reg;
        var_next   = var_reg;
        chain_next = chain_reg;

        // window[0] holds w(t); window[15] receives w(t+16)
        sched = small_sigma1(win_reg[14]) + win_reg[9] + small_sigma0(win_reg[1])
              + win_reg[0];
        t1 = var_reg[7] + big_sigma1(var_reg[4])
           + ((var_reg[4] & var_reg[5]) ^ (~var_reg[4] & var_reg[6]))
           + ctl.k + win_reg[0];
        t2 = big_sigma0(var_reg[0])
           + ((var_reg[0] & var_reg[1]) ^ (var_reg[0] & var_reg[2])
              ^ (var_reg[1] & var_reg[2]));

        if (ctl.shift_in || ctl.round) begin
            for (int i = 0; i < 15; i++) begin
                win_next[i] = win_reg[i + 1];
            end
            win_next[15] = ctl.round ? sched : ctl.word;
        end

        if (ctl.init) begin
            var_next = chain_reg;
        end else if (ctl.round) begin
            var_next[7] = var_reg[6];
            var_next[6] = var_reg[5];
            var_next[5] = var_reg[4];
            var_next[4] = var_reg[3] + t1;
            var_next[3] = var_reg[2];
            var_next[2] = var_reg[1];
            var_next[1] = var_reg[0];
            var_next[0] = t1 + t2;
        end

        if (ctl.chain_init) begin
            chain_next = INIT_H;
        end else if (ctl.fold) begin
            for (int i = 0; i < 8; i++) begin
                chain_next[i] = chain_reg[i] + var_reg[i];
            end
        end

        for (int i = 0; i < 8; i++) begin
            chain_out[i] = chain_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chain_reg <= INIT_H;
        end else begin
            chain_reg <= chain_next;
        end
    end

    always_ff @(posedge aclk) begin
        win_reg <= win_next;
        var_reg <= var_next;
    end

endmodule

/* sv/sha256_message_hasher.sv */
// sha256 message hasher top level: byte intake, padding and round sequencer
// depends on smh_pkg, smh_round and sha256_message_hasher_defines.svh
//
// usage
//   input stream: one message byte per beat in s_tdata[7:0]; s_tlast marks the
//   final beat of a message; s_tuser set means the beat carries no byte (with
//   s_tlast it ends the message, without it the beat is dropped)
//   output stream: one beat per message on m_tdata, digest word 0 (most
//   significant word of the hash) in bits [31:0] up to word 7 in [255:224]
//   flow: bytes are taken one per cycle while s_tready is high; each full
//   64-byte block then runs 64 rounds plus the chain fold in the round
//   unit, during which s_tready is low. at message end the padding and
//   length bytes are fed one per cycle outside compression (up to 72 bytes,
//   spilling into a second block when the tail has 56 bytes or more), then
//   the last block is compressed and ST_OUT loads the digest register after
//   the last fold; throughput is set by the single round unit and byte intake
//   reset: aresetn (synchronous) restores the initial chain value, clears the
//   byte count and drops m_tvalid
//   stall: the digest register holds until m_tready; a following message can
//   be taken meanwhile, but the block waits before overwriting an untaken
//   digest
`timescale 1ns / 1ps
`include "sha256_message_hasher_defines.svh"

module sha256_message_hasher
    import smh_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic         s_tlast,   // is_last
    input  logic         s_tuser,   // no_data
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [255:0] m_tdata    // digest_w0 [31:0] .. digest_w7 [255:224]
);

    smh_state_t      state_reg, state_next;
    logic [5:0]      pos_reg, pos_next;
    logic [60:0]     count_reg, count_next;
    logic [23:0]     acc_reg, acc_next;
    logic [5:0]      rnd_reg, rnd_next;
    logic            pad_reg, pad_next;
    logic            first_reg, first_next;
    logic            final_reg, final_next;
    logic            out_valid_reg, out_valid_next;
    logic [255:0]    out_data_reg, out_data_next;

    smh_ctl_t        ctl;
    logic [7:0][31:0] chain;
    logic            feed;
    logic [7:0]      feed_byte;
    logic            count_inc;
    logic [63:0]     len_shift;

    smh_round u_round (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (ctl),
        .chain_out (chain)
    );

    // big-endian bit length, byte selected by position within the last 8
    assign len_shift = {count_reg, 3'b000} << {pos_reg[2:0], 3'b000};

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        count_next     = count_reg;
        acc_next       = acc_reg;
        rnd_next       = rnd_reg;
        pad_next       = pad_reg;
        first_next     = first_reg;
        final_next     = final_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        ctl            = '0;
        feed           = 1'b0;
        feed_byte      = 8'h00;
        count_inc      = 1'b0;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (!s_tuser) begin
                        feed      = 1'b1;
                        feed_byte = s_tdata;
                        count_inc = 1'b1;
                    end
                    if (s_tlast) begin
                        pad_next   = 1'b1;
                        first_next = 1'b1;
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                feed       = 1'b1;
                feed_byte  = first_reg ? PAD_MARK : 8'h00;
                first_next = 1'b0;
                if (pos_reg == PAD_LAST_POS) begin
                    state_next = ST_LEN;
                end
            end
            ST_LEN: begin
                feed      = 1'b1;
                feed_byte = len_shift[63:56];
                if (pos_reg == BLOCK_LAST_POS) begin
                    final_next = 1'b1;
                end
            end
            ST_COMP: begin
                ctl.round = 1'b1;
                ctl.k     = ROUND_K[rnd_reg];
                rnd_next  = rnd_reg + 6'd1;
                if (rnd_reg == LAST_ROUND) begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD: begin
                ctl.fold = 1'b1;
                if (final_reg) begin
                    state_next = ST_OUT;
                end else if (pad_reg) begin
                    state_next = ST_PAD;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (!out_valid_reg || m_tready) begin
                    out_data_next  = chain;
                    out_valid_next = 1'b1;
                    ctl.chain_init = 1'b1;
                    count_next     = '0;
                    pad_next       = 1'b0;
                    final_next     = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // byte path shared by message, padding and length bytes
        if (feed) begin
            acc_next = {acc_reg[15:0], feed_byte};
            pos_next = pos_reg + 6'd1;
            if (pos_reg[1:0] == 2'b11) begin
                ctl.shift_in = 1'b1;
                ctl.word     = {acc_reg, feed_byte};
            end
            if (pos_reg == BLOCK_LAST_POS) begin
                ctl.init   = 1'b1;
                rnd_next   = '0;
                state_next = ST_COMP;
            end
        end

        if (count_inc) begin
            count_next = count_reg + 61'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            count_reg     <= '0;
            rnd_reg       <= '0;
            pad_reg       <= 1'b0;
            first_reg     <= 1'b0;
            final_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            count_reg     <= count_next;
            rnd_reg       <= rnd_next;
            pad_reg       <= pad_next;
            first_reg     <= first_next;
            final_reg     <= final_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg      <= acc_next;
        out_data_reg <= out_data_next;
    end

    `SMH_CHECK(a_no_shift_clash, !(ctl.shift_in && ctl.round), "window shifted twice")
    `SMH_CHECK_IMPL(a_comp_aligned, state_reg == ST_COMP, pos_reg == '0,
        "rounds running on a partial block")
    `SMH_CHECK_IMPL(a_len_tail, state_reg == ST_LEN, pos_reg[5:3] == 3'b111,
        "length bytes outside the block tail")
    `SMH_CHECK_IMPL(a_fold_after_rounds, state_reg == ST_FOLD,
        $past(state_reg == ST_COMP) && $past(rnd_reg == LAST_ROUND),
        "fold without a complete set of rounds")

endmodule
